// File: rtl/core/mpsc_pkg.sv
package mpsc_pkg;

    // Input points arrive in signed Q4.28
    localparam int IN_FRAC       = 28;
    localparam int FRAC_BITS_DEF = 28;
    // Integer bits of z, sign included; |z| stays below 16 between escape tests
    localparam int INT_BITS      = 6;
    // Digit width of the shared multiplier
    localparam int MUL_DIGIT     = 16;

    localparam int ITER_W = 12;
    localparam logic [ITER_W-1:0] MAX_ITER_RESET = 12'd2000;
    localparam logic [ITER_W-1:0] SHADE_PERIOD   = 12'd251;

    // floor(s*255/250)       = (s  * BLUE_SCALE) >> 24, exact for s  <= 250
    // floor(s*s*255/62500)   = (s2 * RED_SCALE)  >> 40, exact for s2 <= 62500
    localparam logic [24:0] BLUE_SCALE = 25'd17112795;
    localparam logic [32:0] RED_SCALE  = 33'd4486007685;

    typedef struct packed {
        logic signed [31:0] c_real;
        logic signed [31:0] c_imag;
    } point_t;

    typedef struct packed {
        logic [ITER_W-1:0] escape_steps;
        logic              escaped;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
    } shade_t;

endpackage

// File: rtl/core/mpsc_mul.sv
module mpsc_mul #(
    parameter int ZW  = mpsc_pkg::FRAC_BITS_DEF + mpsc_pkg::INT_BITS,
    parameter int DIG = mpsc_pkg::MUL_DIGIT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [ZW-1:0]   a,
    input  logic signed [ZW-1:0]   b,
    output logic                   done,
    output logic signed [2*ZW-1:0] prod
);
    import mpsc_pkg::*;

    localparam int ND    = (ZW + DIG - 1) / DIG;
    localparam int MBW   = ND * DIG;
    localparam int AW    = ZW + MBW;
    localparam int PW    = 2 * ZW;
    localparam int CNT_W = (ND > 1) ? $clog2(ND) : 1;

    typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIX} mul_state_t;

    mul_state_t         state_reg, state_next;
    logic [ZW-1:0]      ma_reg, ma_next;
    logic [MBW-1:0]     mb_reg, mb_next;
    logic               neg_reg, neg_next;
    logic [AW-1:0]      acc_reg, acc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PW-1:0]      prod_reg, prod_next;
    logic               done_reg, done_next;

    logic [ZW-1:0]      a_mag, b_mag;
    logic [ZW+DIG-1:0]  part;
    logic [PW-1:0]      acc_low;

    assign a_mag   = a[ZW-1] ? ZW'(-a) : a;
    assign b_mag   = b[ZW-1] ? ZW'(-b) : b;
    assign part    = (ZW+DIG)'(ma_reg) * (ZW+DIG)'(mb_reg[MBW-1 -: DIG]);
    assign acc_low = acc_reg[PW-1:0];

    always_comb
    begin
        state_next = state_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    ma_next    = a_mag;
                    mb_next    = MBW'(b_mag);
                    neg_next   = a[ZW-1] ^ b[ZW-1];
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = M_RUN;
                end
            end
            M_RUN:
            begin
                // Horner step, most significant digit first
                acc_next = {acc_reg[AW-DIG-1:0], {DIG{1'b0}}} + AW'(part);
                mb_next  = {mb_reg[MBW-DIG-1:0], {DIG{1'b0}}};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ND - 1))
                    state_next = M_FIX;
            end
            M_FIX:
            begin
                prod_next  = neg_reg ? PW'(-acc_low) : acc_low;
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            ma_reg    <= '0;
            mb_reg    <= '0;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            prod_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ma_reg    <= ma_next;
            mb_reg    <= mb_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            prod_reg  <= prod_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// File: rtl/core/mandelbrot_point_shader_core.sv
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-------------------------
// cfg      | in        | cfg_we (no stall)         | cfg_wdata: max_iterations
// point    | in        | point_valid / point_stall | point_t: c_real, c_imag
// shade    | out       | shade_valid / shade_stall | shade_t: steps, color
//
// One point at a time: point_stall is high from acceptance until the result
// is loaded into the output register, which may still wait on shade_stall.
// Each multiply runs on the shared digit-serial multiplier; one iteration is
// three multiplies (zr*zr, zi*zi, zr*zi) plus check and update. After the
// escape test, an inside point goes to output, while an escaped point first
// reduces its step count modulo 251 by repeated subtraction and then computes
// its shade. Async active-low reset.
module mandelbrot_point_shader_core #(
    parameter int FRAC_BITS = mpsc_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mpsc_pkg::ITER_W-1:0]   cfg_wdata,
    input  logic                          point_valid,
    output logic                          point_stall,
    input  mpsc_pkg::point_t              point,
    output logic                          shade_valid,
    input  logic                          shade_stall,
    output mpsc_pkg::shade_t              shade
);
    import mpsc_pkg::*;

    localparam int ZW = FRAC_BITS + INT_BITS;
    localparam int PW = 2 * ZW;
    localparam int CW = ZW + IN_FRAC;
    localparam logic [PW-1:0] FOUR = PW'(1) << (2 * FRAC_BITS + 2);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ_R, S_SQ_I, S_CHECK, S_CROSS, S_UPDATE,
        S_MOD, S_SHADE_SQ, S_SHADE, S_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic signed [ZW-1:0]  cr_reg, cr_next, ci_reg, ci_next;
    logic signed [ZW-1:0]  zr_reg, zr_next, zi_reg, zi_next;
    logic signed [PW-1:0]  rr_reg, rr_next, diff_reg, diff_next;
    logic [ITER_W-1:0]     step_reg, step_next, s_reg, s_next;
    logic [15:0]           sq_reg, sq_next;
    logic [7:0]            red_reg, red_next, blue_reg, blue_next;
    logic                  escaped_reg, escaped_next;
    logic                  mul_start_reg, mul_start_next;
    logic signed [ZW-1:0]  mul_a_reg, mul_a_next, mul_b_reg, mul_b_next;
    logic [ITER_W-1:0]     max_iter_reg, max_iter_next;
    logic                  shade_valid_reg, shade_valid_next;
    shade_t                shade_reg, shade_next;

    logic                  mul_done;
    logic signed [PW-1:0]  mul_prod;

    logic signed [CW-1:0]  cr_ext, ci_ext, cr_shift, ci_shift;
    logic [PW-1:0]         m2;
    logic signed [PW-1:0]  diff_sh, cross_sh;
    logic signed [ZW-1:0]  zr_new, zi_new;
    logic [32:0]           blue_prod;
    logic [48:0]           red_prod;

    mpsc_mul #(
        .ZW  (ZW),
        .DIG (MUL_DIGIT)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // Rescale c from Q4.28 to FRAC_BITS; the right shift floors
    assign cr_ext   = {{(CW-32){point.c_real[31]}}, point.c_real};
    assign ci_ext   = {{(CW-32){point.c_imag[31]}}, point.c_imag};
    assign cr_shift = (cr_ext <<< FRAC_BITS) >>> IN_FRAC;
    assign ci_shift = (ci_ext <<< FRAC_BITS) >>> IN_FRAC;

    assign m2       = rr_reg + mul_prod;
    assign diff_sh  = diff_reg >>> FRAC_BITS;
    assign cross_sh = mul_prod >>> (FRAC_BITS - 1);
    assign zr_new   = ZW'(diff_sh[ZW-1:0]) + cr_reg;
    assign zi_new   = ZW'(cross_sh[ZW-1:0]) + ci_reg;

    assign blue_prod = 33'(s_reg[7:0]) * 33'(BLUE_SCALE);
    assign red_prod  = 49'(sq_reg) * 49'(RED_SCALE);

    always_comb
    begin
        state_next       = state_reg;
        cr_next          = cr_reg;
        ci_next          = ci_reg;
        zr_next          = zr_reg;
        zi_next          = zi_reg;
        rr_next          = rr_reg;
        diff_next        = diff_reg;
        step_next        = step_reg;
        s_next           = s_reg;
        sq_next          = sq_reg;
        red_next         = red_reg;
        blue_next        = blue_reg;
        escaped_next     = escaped_reg;
        mul_start_next   = 1'b0;
        mul_a_next       = mul_a_reg;
        mul_b_next       = mul_b_reg;
        max_iter_next    = cfg_we ? cfg_wdata : max_iter_reg;
        // Drop the output once it is taken
        shade_valid_next = shade_valid_reg & shade_stall;
        shade_next       = shade_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (point_valid)
                begin
                    cr_next        = cr_shift[ZW-1:0];
                    ci_next        = ci_shift[ZW-1:0];
                    zr_next        = '0;
                    zi_next        = '0;
                    step_next      = '0;
                    mul_a_next     = '0;
                    mul_b_next     = '0;
                    mul_start_next = 1'b1;
                    state_next     = S_SQ_R;
                end
            end
            S_SQ_R:
            begin
                if (mul_done)
                begin
                    rr_next        = mul_prod;
                    mul_a_next     = zi_reg;
                    mul_b_next     = zi_reg;
                    mul_start_next = 1'b1;
                    state_next     = S_SQ_I;
                end
            end
            S_SQ_I:
            begin
                if (mul_done)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // mul_prod holds zi^2 here
                diff_next = rr_reg - mul_prod;
                if (m2 >= FOUR)
                begin
                    escaped_next = 1'b1;
                    s_next       = step_reg;
                    state_next   = S_MOD;
                end
                else if (step_reg == max_iter_reg)
                begin
                    escaped_next = 1'b0;
                    red_next     = '0;
                    blue_next    = '0;
                    state_next   = S_EMIT;
                end
                else
                begin
                    mul_a_next     = zr_reg;
                    mul_b_next     = zi_reg;
                    mul_start_next = 1'b1;
                    state_next     = S_CROSS;
                end
            end
            S_CROSS:
            begin
                if (mul_done)
                    state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                zr_next        = zr_new;
                zi_next        = zi_new;
                step_next      = step_reg + 1'b1;
                mul_a_next     = zr_new;
                mul_b_next     = zr_new;
                mul_start_next = 1'b1;
                state_next     = S_SQ_R;
            end
            S_MOD:
            begin
                if (s_reg >= SHADE_PERIOD)
                    s_next = s_reg - SHADE_PERIOD;
                else
                    state_next = S_SHADE_SQ;
            end
            S_SHADE_SQ:
            begin
                sq_next    = 16'(s_reg[7:0]) * 16'(s_reg[7:0]);
                blue_next  = blue_prod[31:24];
                state_next = S_SHADE;
            end
            S_SHADE:
            begin
                red_next   = red_prod[47:40];
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // Hold until the output register is free
                if (!shade_valid_reg || !shade_stall)
                begin
                    shade_valid_next        = 1'b1;
                    shade_next.escape_steps = step_reg;
                    shade_next.escaped      = escaped_reg;
                    shade_next.red          = red_reg;
                    shade_next.green        = red_reg;
                    shade_next.blue         = blue_reg;
                    state_next              = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cr_reg          <= '0;
            ci_reg          <= '0;
            zr_reg          <= '0;
            zi_reg          <= '0;
            rr_reg          <= '0;
            diff_reg        <= '0;
            step_reg        <= '0;
            s_reg           <= '0;
            sq_reg          <= '0;
            red_reg         <= '0;
            blue_reg        <= '0;
            escaped_reg     <= 1'b0;
            mul_start_reg   <= 1'b0;
            mul_a_reg       <= '0;
            mul_b_reg       <= '0;
            max_iter_reg    <= MAX_ITER_RESET;
            shade_valid_reg <= 1'b0;
            shade_reg       <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cr_reg          <= cr_next;
            ci_reg          <= ci_next;
            zr_reg          <= zr_next;
            zi_reg          <= zi_next;
            rr_reg          <= rr_next;
            diff_reg        <= diff_next;
            step_reg        <= step_next;
            s_reg           <= s_next;
            sq_reg          <= sq_next;
            red_reg         <= red_next;
            blue_reg        <= blue_next;
            escaped_reg     <= escaped_next;
            mul_start_reg   <= mul_start_next;
            mul_a_reg       <= mul_a_next;
            mul_b_reg       <= mul_b_next;
            max_iter_reg    <= max_iter_next;
            shade_valid_reg <= shade_valid_next;
            shade_reg       <= shade_next;
        end
    end

    assign point_stall = (state_reg != S_IDLE);
    assign shade_valid = shade_valid_reg;
    assign shade       = shade_reg;

endmodule

// File: rtl/core/mpsc_checker.sv
module mpsc_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             point_valid,
    input logic             point_stall,
    input logic             shade_valid,
    input logic             shade_stall,
    input mpsc_pkg::shade_t shade
);
    import mpsc_pkg::*;

    // An accepted request keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_stall |=> point_stall)
        else $error("point accepted but block not busy next cycle");

    a_shade_hold: assert property (@(posedge clk) disable iff (!rst_n)
        shade_valid && shade_stall |=> shade_valid && $stable(shade))
        else $error("stalled shade request changed");

    a_green_red: assert property (@(posedge clk) disable iff (!rst_n)
        shade_valid |-> shade.green == shade.red)
        else $error("green differs from red");

    a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
        shade_valid && !shade.escaped |->
            shade.red == 8'd0 && shade.green == 8'd0 && shade.blue == 8'd0)
        else $error("inside point not black");

    // Shade is at most one, so its square never exceeds it
    a_red_le_blue: assert property (@(posedge clk) disable iff (!rst_n)
        shade_valid && shade.escaped |-> shade.red <= shade.blue)
        else $error("red above blue");

endmodule

bind mandelbrot_point_shader_core mpsc_checker u_checker (.*);

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
    import mpsc_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int SETTLE      = 40;
    localparam int PERIOD      = 251;

    localparam logic signed [31:0] ZERO     = 32'sh0000_0000;
    localparam logic signed [31:0] TWO      = 32'sh2000_0000;
    localparam logic signed [31:0] NEG_ONE  = 32'shF000_0000;
    localparam logic signed [31:0] NEG_TWO  = 32'shE000_0000;
    localparam logic signed [31:0] MOST_POS = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [31:0] QUARTER  = 32'sh0400_0000;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_we      = 1'b0;
    logic [ITER_W-1:0]   cfg_wdata   = '0;
    logic                point_valid = 1'b0;
    logic                point_stall;
    point_t              point       = '0;
    logic                shade_valid;
    logic                shade_stall = 1'b0;
    shade_t              shade;

    point_t              points_to_send[$];
    shade_t              expected_shades[$];
    logic [ITER_W-1:0]   shade_limit = MAX_ITER_RESET;
    shade_t              want;

    int  points_queued  = 0;
    int  shades_checked = 0;
    int  escaped_count  = 0;
    int  deepest_escape = 0;
    int  limits_written = 0;
    int  mismatches     = 0;
    int  cycle_count    = 0;
    int  gap_left       = 0;
    int  stall_left     = 0;
    bit  steady         = 1'b0;

    mandelbrot_point_shader_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .point_valid(point_valid),
        .point_stall(point_stall),
        .point      (point),
        .shade_valid(shade_valid),
        .shade_stall(shade_stall),
        .shade      (shade)
    );

    always #6 clk = ~clk;

    // Escape-time iteration with exact products and floor shifts, z at 64 bits
    function automatic shade_t shade_of(point_t p, logic [ITER_W-1:0] limit);
        logic signed [63:0]  cr, ci, zr, zi;
        logic signed [127:0] wr, wi, rr, ii, re, ri, four;
        int unsigned         step, s;
        bit                  done;
        shade_t              r;
        cr = 64'($signed(p.c_real));
        ci = 64'($signed(p.c_imag));
        if (FRAC >= IN_FRAC)
        begin
            cr = cr <<< (FRAC - IN_FRAC);
            ci = ci <<< (FRAC - IN_FRAC);
        end
        else
        begin
            cr = cr >>> (IN_FRAC - FRAC);
            ci = ci >>> (IN_FRAC - FRAC);
        end
        four = 128'sd1 <<< (2 * FRAC + 2);
        zr = '0;
        zi = '0;
        step = 0;
        done = 1'b0;
        r = '0;
        while (!done)
        begin
            wr = 128'(zr);
            wi = 128'(zi);
            rr = wr * wr;
            ii = wi * wi;
            if (rr + ii >= four)
            begin
                s = step % PERIOD;
                r.escape_steps = ITER_W'(step);
                r.escaped      = 1'b1;
                r.red          = 8'((s * s * 255) / 62500);
                r.green        = r.red;
                r.blue         = 8'((s * 255) / 250);
                done = 1'b1;
            end
            else if (step == limit)
            begin
                r.escape_steps = ITER_W'(step);
                done = 1'b1;
            end
            else
            begin
                re = (rr - ii) >>> FRAC;
                ri = (wr * wi) >>> (FRAC - 1);
                zr = re[63:0] + cr;
                zi = ri[63:0] + ci;
                step++;
            end
        end
        return r;
    endfunction

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 4);
        return $urandom_range(12, 60);
    endfunction

    function automatic point_t random_point();
        int     pick;
        point_t p;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            // window around the set: real in [-2, 0.5], imag in [-1.25, 1.25]
            p.c_real = $urandom_range(0, 671088640) - 536870912;
            p.c_imag = $urandom_range(0, 671088640) - 335544320;
        end
        else if (pick < 70)
        begin
            // just right of the cusp, where escape is slow
            p.c_real = QUARTER + $urandom_range(0, 1 << 16);
            p.c_imag = $urandom_range(0, 4095) - 2048;
        end
        else if (pick < 90)
        begin
            p.c_real = $urandom;
            p.c_imag = $urandom;
        end
        else
        begin
            case ($urandom_range(0, 4))
                0: p.c_real = MOST_NEG;
                1: p.c_real = MOST_POS;
                2: p.c_real = TWO;
                3: p.c_real = NEG_TWO;
                default: p.c_real = $urandom;
            endcase
            p.c_imag = $urandom_range(0, 1) ? ZERO : $urandom;
        end
        return p;
    endfunction

    task automatic add_point(logic signed [31:0] re, logic signed [31:0] im);
        point_t p;
        p.c_real = re;
        p.c_imag = im;
        points_to_send.push_back(p);
        points_queued++;
    endtask

    task automatic settle();
        while (shades_checked != points_queued)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_limit(logic [ITER_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        limits_written++;
    endtask

    task automatic report(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, int got, int expected_value, int idx);
        if (got != expected_value)
            report($sformatf("shade %0d %s = %0d, predicted %0d", idx, name, got,
                             expected_value));
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (cfg_we)
            shade_limit = cfg_wdata;
        if (!rst_n)
            point_valid <= 1'b0;
        else
        begin
            if (point_valid && !point_stall)
                expected_shades.push_back(shade_of(point, shade_limit));
            if (!point_valid || !point_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    point_valid <= 1'b0;
                end
                else if (points_to_send.size() != 0)
                begin
                    point       <= points_to_send.pop_front();
                    point_valid <= 1'b1;
                    gap_left = (steady || $urandom_range(0, 1)) ? 0 : idle_len();
                end
                else
                    point_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            shade_stall <= 1'b0;
        else
        begin
            if (shade_valid && !shade_stall)
            begin
                if (expected_shades.size() == 0)
                    report("shade returned with no point outstanding");
                else
                begin
                    want = expected_shades.pop_front();
                    check_field("escape_steps", int'(shade.escape_steps),
                                int'(want.escape_steps), shades_checked);
                    check_field("escaped", int'(shade.escaped), int'(want.escaped),
                                shades_checked);
                    check_field("red", int'(shade.red), int'(want.red), shades_checked);
                    check_field("green", int'(shade.green), int'(want.green),
                                shades_checked);
                    check_field("blue", int'(shade.blue), int'(want.blue), shades_checked);
                    if (want.escaped)
                    begin
                        escaped_count++;
                        if (int'(want.escape_steps) > deepest_escape)
                            deepest_escape = int'(want.escape_steps);
                    end
                    shades_checked++;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                shade_stall <= 1'b1;
            end
            else
            begin
                shade_stall <= 1'b0;
                if (!steady && $urandom_range(0, 99) < 20)
                    stall_left = idle_len();
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("cycle limit hit with %0d of %0d shades checked", shades_checked,
                 points_queued);
        $display("mandelbrot_point_shader_core test failed");
        $finish;
    end

    initial
    begin : stimulus
        int     ph;
        point_t rp;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limit: origin runs to 2000, points with |c| >= 2 escape at step 1
        add_point(ZERO, ZERO);
        add_point(TWO, ZERO);
        add_point(NEG_TWO, ZERO);
        add_point(ZERO, TWO);
        add_point(ZERO, NEG_TWO);
        add_point(MOST_POS, MOST_POS);
        add_point(MOST_NEG, MOST_NEG);
        add_point(MOST_NEG, MOST_POS);
        add_point(32'shF400_0000, 32'sh0199_999A);
        settle();

        // widest limit: slow escapes past the shade period, one long inside run
        write_limit(12'd4095);
        add_point(32'sh0400_0100, ZERO);
        add_point(32'sh0400_8000, ZERO);
        add_point(NEG_ONE, ZERO);
        add_point(32'sh04CC_CCCD, 32'sh0800_0000);
        settle();

        // zero limit: every point is inside at step zero
        write_limit(12'd0);
        add_point(ZERO, ZERO);
        add_point(MOST_POS, MOST_NEG);
        add_point($urandom, $urandom);
        settle();

        write_limit(12'd1);
        add_point(TWO, ZERO);
        add_point(32'sh1E66_6666, ZERO);
        add_point(ZERO, ZERO);
        settle();

        for (ph = 0; ph < 6; ph++)
        begin
            steady = (ph == 2) || ($urandom_range(0, 5) == 0);
            write_limit(ph == 4 ? 12'd300 : ITER_W'($urandom_range(2, 120)));
            repeat (48)
            begin
                rp = random_point();
                add_point(rp.c_real, rp.c_imag);
            end
            settle();
        end

        $display("%0d points shaded under %0d limit writes: %0d escaped (deepest step %0d)",
                 shades_checked, limits_written, escaped_count, deepest_escape);
        $display("%0d points ran to their limit, %0d cycles", shades_checked - escaped_count,
                 cycle_count);
        if (mismatches == 0)
            $display("mandelbrot_point_shader_core test passed");
        else
            $display("mandelbrot_point_shader_core test failed");
        $finish;
    end

endmodule
